>>> sv/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
// Request and status codes, and the command and status groups between controller and datapath.
// No dependencies.
package bba_pkg;

  localparam int BLOCK_SHIFT = 12;
  localparam int ADDR_W      = 32;
  localparam int IDX_W       = ADDR_W - BLOCK_SHIFT;
  localparam int TOTAL_W     = 13;
  localparam int RES_ADDR_W  = 24;
  localparam int TOTAL_RESET = 4096;
  localparam int TOTAL_CAP   = 8191;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_RESERVE = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOCHANGE  = 2'd2;

  typedef struct packed {
    logic       load;      // latch a new request
    logic       clr_wr;    // write one zero word of the clearing pass
    logic       rd_issue;  // issue a map read
    logic       rd_tgt;    // read the target word rather than the scan word
    logic       capture;   // capture the modified word
    logic       cap_scan;  // the capture comes from the scan
    logic       wr_en;     // write the captured word back and update the count
    logic       respond;   // present a result
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic tgt_ok;          // free or reserve within the managed range
    logic scan_more;
    logic pend;
    logic word_has_free;
    logic found_ok;
    logic needs_change;
  } stat_t;

endpackage

>>> sv/bitmap_block_allocator.sv
// Bitmap allocator of 4096-byte blocks. An allocate request scans the map word-serially over
// the W 32-bit map words below the total (W = 128 at 4096 blocks); free, reserve and unknown
// kinds take no scan.
// One request at a time; the result strobe rises the cycle busy falls, the receiver cannot stall.
// After a synchronous reset a clearing pass writes every map word while busy; configuration
// writes are taken throughout. Depends on bba_pkg, bba_ctrl, bba_dpath.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_kind,
  input  logic [bba_pkg::ADDR_W-1:0]       in_block_address,
  output logic                             out_strobe,
  output logic [1:0]                       out_status,
  output logic [bba_pkg::RES_ADDR_W-1:0]   out_result_address,
  output logic [bba_pkg::TOTAL_W-1:0]      out_used_count,
  input  logic                             cfg_wr_en,
  input  logic [bba_pkg::TOTAL_W-1:0]      cfg_block_limit
);

  bba_pkg::cmd_t                cmd;
  bba_pkg::stat_t               stat;
  logic [bba_pkg::TOTAL_W-1:0]  total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= bba_pkg::TOTAL_W'(bba_pkg::TOTAL_RESET);
    end else if (cfg_wr_en) begin
      total_r <= cfg_block_limit;
    end
  end

  bba_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  bba_dpath #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (in_kind),
    .in_block_address  (in_block_address),
    .block_limit       (total_r),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_result_address(out_result_address),
    .out_used_count    (out_used_count)
  );

`ifndef NO_ASSERTIONS
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) && !busy))
    else $error("result transfer not at the end of a busy period");
`endif

endmodule

>>> sv/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/bba_ctrl.sv
// Controller of the bitmap block allocator: clearing pass, request decode, scan and write-back.
// Depends on bba_pkg.
module bba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bba_pkg::stat_t stat,
  output logic          busy,
  output bba_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLEAR  = 6'b000010,
    S_DECODE = 6'b000100,
    S_TEVAL  = 6'b001000,
    S_SCAN   = 6'b010000,
    S_WRITE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = bba_pkg::ST_NOCHANGE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DECODE: begin
        priority if (stat.is_alloc) begin
          state_nxt = S_SCAN;
        end else if (stat.tgt_ok) begin
          cmd.rd_issue = 1'b1;
          cmd.rd_tgt   = 1'b1;
          state_nxt    = S_TEVAL;
        end else begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_TEVAL: begin
        if (stat.needs_change) begin
          cmd.capture = 1'b1;
          state_nxt   = S_WRITE;
        end else begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_SCAN: begin
        // Reads run one word ahead of the word being examined.
        cmd.rd_issue = stat.scan_more && !(stat.pend && stat.word_has_free);
        priority if (stat.pend && stat.word_has_free) begin
          if (stat.found_ok) begin
            cmd.capture  = 1'b1;
            cmd.cap_scan = 1'b1;
            state_nxt    = S_WRITE;
          end else begin
            cmd.respond = 1'b1;
            cmd.status  = bba_pkg::ST_FULL;
            state_nxt   = S_IDLE;
          end
        end else if (!stat.pend && !stat.scan_more) begin
          cmd.respond = 1'b1;
          cmd.status  = bba_pkg::ST_FULL;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_WRITE: begin
        cmd.wr_en   = 1'b1;
        cmd.respond = 1'b1;
        cmd.status  = bba_pkg::ST_DONE;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

`ifndef NO_ASSERTIONS
  a_write_from_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> $past(cmd.capture))
    else $error("write-back without a captured word");
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");
`endif

endmodule

>>> sv/bba_dpath.sv
// Datapath of the bitmap block allocator: used-bit map memory, scan pointers, count and result.
// Depends on bba_pkg and bba_ram.
module bba_dpath #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bba_pkg::cmd_t                       cmd,
  output bba_pkg::stat_t                      stat,
  input  logic [1:0]                          in_kind,
  input  logic [bba_pkg::ADDR_W-1:0]          in_block_address,
  input  logic [bba_pkg::TOTAL_W-1:0]         block_limit,
  output logic                                out_strobe,
  output logic [1:0]                          out_status,
  output logic [bba_pkg::RES_ADDR_W-1:0]      out_result_address,
  output logic [bba_pkg::TOTAL_W-1:0]         out_used_count
);

  localparam int LIM_MAX   = (MAX_BLOCKS < bba_pkg::TOTAL_CAP) ? MAX_BLOCKS : bba_pkg::TOTAL_CAP;
  localparam int LW        = $clog2(LIM_MAX + 1);
  localparam int MEM_WORDS = (LIM_MAX + 31) / 32;
  localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int SPW       = $clog2(MEM_WORDS + 1);
  localparam int CW        = (SPW + 5 > LW) ? SPW + 5 : LW;

  logic [LW-1:0]                     lim;
  logic [1:0]                        kind_r;
  logic [bba_pkg::IDX_W-1:0]         idx_r;
  logic [SPW-1:0]                    scan_ptr_r;
  logic [AW-1:0]                     pend_ptr_r;
  logic                              pend_r;
  logic [AW-1:0]                     clr_ptr_r;
  logic [31:0]                       word_r;
  logic [bba_pkg::TOTAL_W-1:0]       used_r;
  logic                              out_strobe_r;
  logic [1:0]                        out_status_r;
  logic [bba_pkg::RES_ADDR_W-1:0]    out_addr_r;

  logic [AW-1:0]  rd_addr, wr_addr;
  logic [31:0]    rd_data, wr_data, flip_mask;
  logic           mem_wr;
  logic [4:0]     free_bit, bit_pos;
  logic           tgt_bit;

  assign lim = (32'(block_limit) > LIM_MAX) ? LW'(LIM_MAX) : LW'(block_limit);

  assign rd_addr = cmd.rd_tgt ? idx_r[AW+4:5] : scan_ptr_r[AW-1:0];
  assign mem_wr  = cmd.clr_wr || cmd.wr_en;
  assign wr_addr = cmd.clr_wr ? clr_ptr_r : idx_r[AW+4:5];
  assign wr_data = cmd.clr_wr ? 32'd0 : word_r;

  bba_ram #(
    .WIDTH(32),
    .DEPTH(MEM_WORDS)
  ) u_map (
    .clk    (clk),
    .wr_en  (mem_wr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_issue),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Lowest clear bit of the word just read.
  always_comb begin
    free_bit = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!rd_data[i]) begin
        free_bit = 5'(i);
      end
    end
  end

  assign tgt_bit   = rd_data[idx_r[4:0]];
  assign bit_pos   = cmd.cap_scan ? free_bit : idx_r[4:0];
  assign flip_mask = 32'd1 << bit_pos;

  always_comb begin
    stat               = '0;
    stat.clr_last      = (clr_ptr_r == AW'(MEM_WORDS - 1));
    stat.is_alloc      = (kind_r == bba_pkg::KIND_ALLOC);
    stat.tgt_ok        = ((kind_r == bba_pkg::KIND_FREE) || (kind_r == bba_pkg::KIND_RESERVE))
                         && (idx_r < bba_pkg::IDX_W'(lim));
    stat.scan_more     = (CW'({scan_ptr_r, 5'd0}) < CW'(lim));
    stat.pend          = pend_r;
    stat.word_has_free = !(&rd_data);
    stat.found_ok      = (CW'({pend_ptr_r, free_bit}) < CW'(lim));
    stat.needs_change  = ((kind_r == bba_pkg::KIND_FREE) && tgt_bit)
                         || ((kind_r == bba_pkg::KIND_RESERVE) && !tgt_bit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_ptr_r   <= '0;
      pend_r       <= 1'b0;
      clr_ptr_r    <= '0;
      used_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      pend_r       <= cmd.rd_issue && !cmd.rd_tgt;
      out_strobe_r <= cmd.respond;
      if (cmd.clr_wr) begin
        clr_ptr_r <= clr_ptr_r + AW'(1);
      end
      if (cmd.load) begin
        scan_ptr_r <= '0;
      end else if (cmd.rd_issue && !cmd.rd_tgt) begin
        scan_ptr_r <= scan_ptr_r + SPW'(1);
      end
      if (cmd.wr_en) begin
        if (kind_r == bba_pkg::KIND_FREE) begin
          used_r <= used_r - bba_pkg::TOTAL_W'(1);
        end else begin
          used_r <= used_r + bba_pkg::TOTAL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      idx_r  <= in_block_address[bba_pkg::ADDR_W-1:bba_pkg::BLOCK_SHIFT];
    end else if (cmd.capture && cmd.cap_scan) begin
      idx_r  <= bba_pkg::IDX_W'({pend_ptr_r, free_bit});
    end
    if (cmd.rd_issue && !cmd.rd_tgt) begin
      pend_ptr_r <= scan_ptr_r[AW-1:0];
    end
    if (cmd.capture) begin
      word_r <= rd_data ^ flip_mask;
    end
    if (cmd.respond) begin
      out_status_r <= cmd.status;
      if ((cmd.status == bba_pkg::ST_DONE) && (kind_r == bba_pkg::KIND_ALLOC)) begin
        out_addr_r <= bba_pkg::RES_ADDR_W'({idx_r, {bba_pkg::BLOCK_SHIFT{1'b0}}});
      end else begin
        out_addr_r <= '0;
      end
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;
  assign out_used_count     = used_r;

`ifndef NO_ASSERTIONS
  a_write_reports_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |=> (out_strobe_r && (out_status_r == bba_pkg::ST_DONE)))
    else $error("map write-back not reported as done");
  a_count_moves_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r)) |-> (out_strobe_r && (out_status_r == bba_pkg::ST_DONE)))
    else $error("used count changed without a completed request");
`endif

endmodule
